// ===== rtl/sobel_pkg.sv =====
// Shared types and constants of the Sobel edge magnitude block.
package sobel_pkg;

   // Channel sum of one pixel: up to three 8-bit channels.
   localparam int SUM_W = 10;
   // Signed gradient: a weighted column sum of 12 bits minus another.
   localparam int GRAD_W = 13;
   // Sum of the two squared gradients.
   localparam int SQ_W = 25;
   // Working width of the square-root unit, one bit above the radicand.
   localparam int ROOT_W = SQ_W + 1;
   // Bits of the final root, and iterations of the root unit (two bits each).
   localparam int ROOT_OUT_W = 13;
   localparam int ROOT_STEPS = 13;
   localparam int STEP_W = $clog2(ROOT_STEPS);
   // Root divided by four.
   localparam int QUOT_W = ROOT_OUT_W - 2;
   // Reciprocal of three, scaled by two to the RECIP_SHIFT.
   localparam int RECIP_W = 10;
   localparam int RECIP_SHIFT = 11;
   localparam logic [RECIP_W-1:0] RECIP_THREE = 10'd683;

   // Result limits.
   localparam logic [7:0] EDGE_MAX = 8'd255;

   // Configuration registers.
   localparam int CSR_DATA_W = 12;
   localparam int WIDTH_REG_W = 12;
   localparam int CHAN_REG_W = 3;
   localparam logic CSR_IMAGE_WIDTH = 1'b0;
   localparam logic CSR_CHANNEL_COUNT = 1'b1;
   localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RESET = 12'd640;
   localparam logic [CHAN_REG_W-1:0] CHANNEL_COUNT_RESET = 3'd3;
   localparam int MIN_WIDTH = 3;

   // Commands from the sequencer to the datapath; at most one is high.
   typedef struct packed {
      logic accept;
      logic read;
      logic grad;
      logic square;
      logic root_step;
      logic scale;
      logic load_out;
   } sobel_cmd_type;

endpackage

// ===== rtl/sobel_ctrl.sv =====
// Sequencer of the Sobel edge magnitude block: one pixel at a time.
module sobel_ctrl
   import sobel_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          rsp_tready,
   output logic          rsp_tvalid,
   output sobel_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_GRAD,
      ST_SQUARE,
      ST_ROOT,
      ST_SCALE,
      ST_OUTPUT
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_GRAD;
         end
         ST_GRAD: begin
            cmd.grad = 1'b1;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            step_in    = '0;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            // The output register takes the result once it is free or being emptied.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output transaction flag.
   always_comb begin
      priority if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/sobel_dpath.sv =====
// Datapath of the Sobel edge magnitude block: line stores, window, gradients,
// square root and scaling.
module sobel_dpath
   import sobel_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  sobel_cmd_type         cmd,
   input  logic [23:0]           req_tdata,
   input  logic                  req_tuser,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tuser
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int CMPW = (CW > WIDTH_REG_W) ? CW : WIDTH_REG_W;

   // Configuration registers.
   logic [WIDTH_REG_W-1:0] image_width_ff;
   logic [CHAN_REG_W-1:0]  channel_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= IMAGE_WIDTH_RESET;
         channel_count_ff <= CHANNEL_COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_wdata[WIDTH_REG_W-1:0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[CHAN_REG_W-1:0];
            default:           image_width_ff   <= image_width_ff;
         endcase
      end
   end

   // Effective channel count (one to three) and row width (three to MAX_WIDTH).
   logic [1:0]      chan_n;
   logic [CMPW-1:0] width_ext, width_eff;

   always_comb begin
      if (channel_count_ff == '0) begin
         chan_n = 2'd1;
      end else if (channel_count_ff > CHAN_REG_W'(3)) begin
         chan_n = 2'd3;
      end else begin
         chan_n = channel_count_ff[1:0];
      end
      width_ext = CMPW'(image_width_ff);
      if (width_ext < CMPW'(MIN_WIDTH)) begin
         width_eff = CMPW'(MIN_WIDTH);
      end else if (width_ext > CMPW'(MAX_WIDTH)) begin
         width_eff = CMPW'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
   end

   // Intensity of the incoming pixel as a plain channel sum.
   logic [SUM_W-1:0] pixel_sum;

   always_comb begin
      pixel_sum = SUM_W'(req_tdata[7:0]);
      if (chan_n >= 2'd2) begin
         pixel_sum = pixel_sum + SUM_W'(req_tdata[15:8]);
      end
      if (chan_n == 2'd3) begin
         pixel_sum = pixel_sum + SUM_W'(req_tdata[23:16]);
      end
   end

   // Position of the pixel in hand and of the next one.
   logic [CW-1:0]    col_ff, column_pos_ff;
   logic [1:0]       row_ff, row_pos_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [CMPW-1:0]  col_next;

   assign col_next = CMPW'(col_ff) + CMPW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         column_pos_ff <= '0;
         row_pos_ff    <= '0;
      end else if (cmd.grad) begin
         // Step along the row, wrapping at its end; the row count stops at two.
         if (col_next >= width_eff) begin
            column_pos_ff <= '0;
            if (row_ff < 2'd2) begin
               row_pos_ff <= row_ff + 2'd1;
            end else begin
               row_pos_ff <= row_ff;
            end
         end else begin
            column_pos_ff <= CW'(col_next);
            row_pos_ff    <= row_ff;
         end
      end
   end

   // Capture of the accepted transaction; a frame start restarts the position.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sum_ff <= pixel_sum;
         if (req_tuser) begin
            col_ff <= '0;
            row_ff <= '0;
         end else begin
            col_ff <= column_pos_ff;
            row_ff <= row_pos_ff;
         end
      end
   end

   // Line stores: the upper holds row r-2, the lower row r-1.
   logic [SUM_W-1:0] upper_mem [MAX_WIDTH];
   logic [SUM_W-1:0] lower_mem [MAX_WIDTH];
   logic [SUM_W-1:0] upper_rd_ff, lower_rd_ff;
   logic [AW-1:0]    mem_addr;

   assign mem_addr = col_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         upper_rd_ff <= upper_mem[mem_addr];
         lower_rd_ff <= lower_mem[mem_addr];
      end
      if (cmd.grad) begin
         upper_mem[mem_addr] <= lower_rd_ff;
         lower_mem[mem_addr] <= sum_ff;
      end
   end

   // Window: left column in entries 0 to 2, middle in 3 to 5, top to bottom.
   logic [SUM_W-1:0] window_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            window_ff[i] <= '0;
         end
      end else if (cmd.grad) begin
         window_ff[0] <= window_ff[3];
         window_ff[1] <= window_ff[4];
         window_ff[2] <= window_ff[5];
         window_ff[3] <= upper_rd_ff;
         window_ff[4] <= lower_rd_ff;
         window_ff[5] <= sum_ff;
      end
   end

   // Sobel gradients; the right column is the line store outputs and the new sum.
   logic [GRAD_W-1:0]        right_x, left_x, bottom_y, top_y;
   logic signed [GRAD_W-1:0] gx_in, gy_in, gx_ff, gy_ff;
   logic                     interior_ff;

   always_comb begin
      right_x  = GRAD_W'(upper_rd_ff) + (GRAD_W'(lower_rd_ff) << 1) + GRAD_W'(sum_ff);
      left_x   = GRAD_W'(window_ff[0]) + (GRAD_W'(window_ff[1]) << 1)
               + GRAD_W'(window_ff[2]);
      bottom_y = GRAD_W'(window_ff[2]) + (GRAD_W'(window_ff[5]) << 1) + GRAD_W'(sum_ff);
      top_y    = GRAD_W'(window_ff[0]) + (GRAD_W'(window_ff[3]) << 1)
               + GRAD_W'(upper_rd_ff);
      gx_in    = signed'(right_x - left_x);
      gy_in    = signed'(bottom_y - top_y);
   end

   always_ff @(posedge clock) begin
      if (cmd.grad) begin
         gx_ff       <= gx_in;
         gy_ff       <= gy_in;
         interior_ff <= (row_ff == 2'd2) && (col_ff >= CW'(2));
      end
   end

   // Squared magnitude, then a two-bits-per-step integer square root.
   logic [2*GRAD_W-1:0] gx_sq, gy_sq;
   logic [ROOT_W-1:0]   rem_ff, root_ff, bit_ff, trial;

   assign gx_sq = unsigned'((2*GRAD_W)'(gx_ff) * (2*GRAD_W)'(gx_ff));
   assign gy_sq = unsigned'((2*GRAD_W)'(gy_ff) * (2*GRAD_W)'(gy_ff));
   assign trial = root_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         rem_ff  <= ROOT_W'(gx_sq[SQ_W-1:0]) + ROOT_W'(gy_sq[SQ_W-1:0]);
         root_ff <= '0;
         bit_ff  <= ROOT_W'(1) << (2 * (ROOT_STEPS - 1));
      end else if (cmd.root_step) begin
         if (rem_ff >= trial) begin
            rem_ff  <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // Division by four times the channel count, with saturation; border centres give zero.
   logic [QUOT_W-1:0]         quot;
   logic [QUOT_W+RECIP_W-1:0] third_prod;
   logic [QUOT_W-1:0]         mag;
   logic [7:0]                edge_in, edge_ff;
   logic                      flag_ff;

   always_comb begin
      quot       = root_ff[ROOT_OUT_W-1:2];
      third_prod = (QUOT_W + RECIP_W)'(quot) * (QUOT_W + RECIP_W)'(RECIP_THREE);
      unique case (chan_n)
         2'd2:    mag = quot >> 1;
         2'd3:    mag = QUOT_W'(third_prod >> RECIP_SHIFT);
         default: mag = quot;
      endcase
      if (!interior_ff) begin
         edge_in = '0;
      end else if (mag > QUOT_W'(EDGE_MAX)) begin
         edge_in = EDGE_MAX;
      end else begin
         edge_in = mag[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         edge_ff <= edge_in;
         flag_ff <= interior_ff;
      end
   end

   // Output register, loaded when the outgoing side is free or being emptied.
   logic [7:0] rsp_edge_ff;
   logic       rsp_flag_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_edge_ff <= edge_ff;
         rsp_flag_ff <= flag_ff;
      end
   end

   assign rsp_tdata = rsp_edge_ff;
   assign rsp_tuser = rsp_flag_ff;

endmodule

// ===== rtl/sobel_edge_magnitude.sv =====
// Top level of the streaming 3x3 Sobel edge magnitude block.
//
// Pixels enter in raster order on the req_ channel, one transaction per pixel,
// with tuser high on the first pixel of a frame. Each pixel gives one
// transaction on the rsp_ channel: the saturated gradient magnitude of the
// window centre (one row up and one column left) and a flag that is high
// when that centre is an interior pixel; border centres give zero.
// The csr_ port writes the row width (index 0) and the channel count
// (index 1); write it only while no pixel is in flight.
// A pixel is accepted, its line store entry read, gradients formed, squared,
// put through a 13-step square-root unit and scaled; the result then goes to
// the output register, and a new pixel is taken only once the last result
// has been loaded there.
// Reset clears the sequencer, window and positions and restores the register
// defaults (width 640, three channels); the line stores are not cleared.
// While the receiver stalls the result waits in the output register; the
// next pixel is taken and processed meanwhile and then waits to be loaded.
module sobel_edge_magnitude
   import sobel_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,  // chan_first, chan_second, chan_third
   input  logic                  req_tuser,  // frame_start
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,  // edge_value
   output logic                  rsp_tuser,  // center_valid
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   sobel_cmd_type cmd;

   sobel_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   sobel_dpath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // Only one pixel is in flight: no new transaction right after one is taken.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted on consecutive cycles");

   // The sequencer issues at most one command per cycle.
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("several datapath commands at once");

   // Loading the output register always presents a result.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_tvalid)
      else $error("loaded result not presented");

   // A result taken without a new load leaves the output empty.
   a_taken_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !cmd.load_out |=> !rsp_tvalid)
      else $error("result repeated after transaction");

endmodule
